[rtl/tsc_pkg.sv]
// Shared types and constants of the token scanner.
`timescale 1ns / 1ps
package tsc_pkg;

  localparam int TEXT_BYTES = 65536;
  localparam int LINE_LIMIT = 65535;
  localparam int POS_W      = 16;
  localparam int LINE_W     = 16;
  localparam int LEN_W      = 16;
  localparam int WORD_MAX   = 6;
  localparam int WLEN_W     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(TEXT_BYTES - 1);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_LIMIT);

  typedef enum logic [4:0] {
    K_LPAREN   = 5'd0,
    K_RPAREN   = 5'd1,
    K_LBRACE   = 5'd2,
    K_RBRACE   = 5'd3,
    K_LBRACKET = 5'd4,
    K_RBRACKET = 5'd5,
    K_COLON    = 5'd6,
    K_INPUT    = 5'd7,
    K_OUTPUT   = 5'd8,
    K_STR      = 5'd9,
    K_NUM      = 5'd10,
    K_BOOL     = 5'd11,
    K_LIST     = 5'd12,
    K_BOOLEAN  = 5'd13,
    K_CHECK    = 5'd14,
    K_NUMBER   = 5'd15,
    K_STRING   = 5'd16,
    K_COMMENT  = 5'd17,
    K_EOF      = 5'd18,
    K_ERR_CHAR = 5'd19,
    K_ERR_STR  = 5'd20
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  start_pos;
    logic [LEN_W-1:0]  length;
    logic [LINE_W-1:0] line_no;
    logic              last;
  } tok_t;

  // Up to two tokens come out of one text byte.
  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } tok_pair_t;

endpackage

[rtl/tsc_front.sv]
// Front end: byte classification, scan state and token assembly.
`timescale 1ns / 1ps
module tsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output tsc_pkg::tok_pair_t q_pair
);
  import tsc_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_DQ   = 3'd3,
    MODE_SQ   = 3'd4,
    MODE_CMT  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_FRAC   = 2'd2
  } phase_t;

  mode_t             mode, mode_next;
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  position, position_next;
  logic [POS_W-1:0]  token_start, token_start_next;
  logic [LINE_W-1:0] line_number, line_number_next;
  logic [WLEN_W-1:0] word_length, word_length_next;
  logic              word_overflow, word_overflow_next;
  logic [WORD_MAX-1:0][7:0] word_buffer;

  logic              wbuf_we;
  logic [WLEN_W-1:0] wbuf_idx;
  logic              accept;
  logic              is_letter, is_numeral, is_newline;
  logic [LINE_W-1:0] line_inc;
  logic [POS_W-1:0]  span;
  logic [7:0]        quote;

  logic              close_v, scan_v;
  kind_t             close_kind, scan_kind;
  logic [LEN_W:0]    close_len;
  logic [POS_W-1:0]  scan_start;
  logic [LEN_W-1:0]  scan_len;
  logic              rescan;
  tok_t              close_tok, scan_tok;

  // Right-aligned literal of tlen bytes against the held letters.
  function automatic logic word_is(input logic [WORD_MAX-1:0][7:0] wb,
                                   input logic [WLEN_W-1:0] wl,
                                   input logic [8*WORD_MAX-1:0] text,
                                   input int tlen);
    logic ok;
    ok = (int'(wl) == tlen);
    for (int j = 0; j < WORD_MAX; j++) begin
      if (j < tlen) begin
        if (wb[j] != text[8*(tlen-1-j) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic kind_t word_kind(input logic [WORD_MAX-1:0][7:0] wb,
                                      input logic [WLEN_W-1:0] wl,
                                      input logic ovf);
    kind_t k;
    k = K_ERR_CHAR;
    if (!ovf) begin
      if (word_is(wb, wl, 48'("input"), 5))       k = K_INPUT;
      else if (word_is(wb, wl, 48'("output"), 6)) k = K_OUTPUT;
      else if (word_is(wb, wl, 48'("str"), 3))    k = K_STR;
      else if (word_is(wb, wl, 48'("num"), 3))    k = K_NUM;
      else if (word_is(wb, wl, 48'("bool"), 4))   k = K_BOOL;
      else if (word_is(wb, wl, 48'("list"), 4))   k = K_LIST;
      else if (word_is(wb, wl, 48'("true"), 4))   k = K_BOOLEAN;
      else if (word_is(wb, wl, 48'("false"), 5))  k = K_BOOLEAN;
      else if (word_is(wb, wl, 48'("check"), 5))  k = K_CHECK;
    end
    return k;
  endfunction

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign is_letter  = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  assign is_numeral = ch >= "0" && ch <= "9";
  assign is_newline = ch == 8'h0a;
  assign line_inc   = (line_number < LINE_MAX) ? line_number + 1'b1 : line_number;
  assign span       = position - token_start;
  assign quote      = (mode == MODE_DQ) ? 8'h22 : 8'h27;

  always_comb begin
    mode_next          = mode;
    phase_next         = phase;
    token_start_next   = token_start;
    line_number_next   = line_number;
    word_length_next   = word_length;
    word_overflow_next = word_overflow;
    position_next      = (position < POS_MAX) ? position + 1'b1 : position;
    wbuf_we            = 1'b0;
    wbuf_idx           = word_length;
    close_v            = 1'b0;
    close_kind         = K_ERR_CHAR;
    close_len          = {1'b0, span};
    scan_v             = 1'b0;
    scan_kind          = K_ERR_CHAR;
    scan_start         = position;
    scan_len           = LEN_W'(1);
    rescan             = 1'b1;

    // Close or extend the pending token.
    unique case (mode)
      MODE_WORD: begin
        if (is_letter) begin
          rescan = 1'b0;
          if (int'(word_length) < WORD_MAX) begin
            wbuf_we          = 1'b1;
            word_length_next = word_length + 1'b1;
          end else begin
            word_overflow_next = 1'b1;
          end
        end else begin
          close_v    = 1'b1;
          close_kind = word_kind(word_buffer, word_length, word_overflow);
          mode_next  = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (phase == PH_FIRST && ch == "-") begin
          phase_next = PH_DIGITS;
          rescan     = 1'b0;
        end else if (is_numeral) begin
          if (phase == PH_FIRST) phase_next = PH_DIGITS;
          rescan = 1'b0;
        end else if (ch == "." && phase != PH_FRAC) begin
          phase_next = PH_FRAC;
          rescan     = 1'b0;
        end else begin
          close_v    = 1'b1;
          close_kind = K_NUMBER;
          mode_next  = MODE_IDLE;
        end
      end
      MODE_DQ, MODE_SQ: begin
        if (ch == 8'h00) begin
          close_v    = 1'b1;
          close_kind = K_ERR_STR;
          mode_next  = MODE_IDLE;
        end else begin
          rescan = 1'b0;
          if (ch == quote) begin
            close_v    = 1'b1;
            close_kind = K_STRING;
            close_len  = {1'b0, span} + 1'b1;
            mode_next  = MODE_IDLE;
          end else if (is_newline) begin
            line_number_next = line_inc;
          end
        end
      end
      MODE_CMT: begin
        if (is_newline || ch == 8'h00) begin
          close_v    = 1'b1;
          close_kind = K_COMMENT;
          mode_next  = MODE_IDLE;
        end else begin
          rescan = 1'b0;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase

    // Scan the byte as the start of a new token.
    if (rescan) begin
      if (ch == 8'h00) begin
        scan_v           = 1'b1;
        scan_kind        = K_EOF;
        scan_len         = '0;
        position_next    = '0;
        line_number_next = LINE_W'(1);
        mode_next        = MODE_IDLE;
        phase_next       = PH_FIRST;
      end else if (ch == " " || ch == 8'h09 || ch == 8'h0d) begin
        // skip blank
      end else if (is_newline) begin
        line_number_next = line_inc;
      end else if (is_letter) begin
        mode_next          = MODE_WORD;
        token_start_next   = position;
        wbuf_we            = 1'b1;
        wbuf_idx           = '0;
        word_length_next   = WLEN_W'(1);
        word_overflow_next = 1'b0;
      end else if (is_numeral || ch == "-") begin
        mode_next        = MODE_NUM;
        phase_next       = PH_FIRST;
        token_start_next = position;
      end else if (ch == 8'h22 || ch == 8'h27) begin
        mode_next        = (ch == 8'h22) ? MODE_DQ : MODE_SQ;
        token_start_next = position;
      end else if (ch == "#") begin
        mode_next        = MODE_CMT;
        token_start_next = position;
      end else begin
        scan_v = 1'b1;
        unique case (ch)
          "(":     scan_kind = K_LPAREN;
          ")":     scan_kind = K_RPAREN;
          "{":     scan_kind = K_LBRACE;
          "}":     scan_kind = K_RBRACE;
          "[":     scan_kind = K_LBRACKET;
          "]":     scan_kind = K_RBRACKET;
          ":":     scan_kind = K_COLON;
          default: scan_kind = K_ERR_CHAR;
        endcase
      end
    end
  end

  always_comb begin
    close_tok.kind      = close_kind;
    close_tok.start_pos = token_start;
    close_tok.length    = close_len[LEN_W] ? '1 : close_len[LEN_W-1:0];
    close_tok.line_no   = line_number;
    close_tok.last      = !scan_v;
    scan_tok.kind       = scan_kind;
    scan_tok.start_pos  = scan_start;
    scan_tok.length     = scan_len;
    scan_tok.line_no    = line_number;
    scan_tok.last       = 1'b1;
    q_pair.first        = close_v ? close_tok : scan_tok;
    q_pair.second       = scan_tok;
    q_pair.two          = close_v && scan_v;
  end

  assign q_push = accept && (close_v || scan_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      phase         <= PH_FIRST;
      position      <= '0;
      token_start   <= '0;
      line_number   <= LINE_W'(1);
      word_length   <= '0;
      word_overflow <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      phase         <= phase_next;
      position      <= position_next;
      token_start   <= token_start_next;
      line_number   <= line_number_next;
      word_length   <= word_length_next;
      word_overflow <= word_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wbuf_we) begin
      word_buffer[wbuf_idx] <= ch;
    end
  end

endmodule

[rtl/tsc_fifo.sv]
// Short queue of token pairs between the front and back ends.
`timescale 1ns / 1ps
module tsc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tsc_pkg::tok_pair_t push_pair,
  output logic               full,
  input  logic               pop,
  output tsc_pkg::tok_pair_t pop_pair,
  output logic               empty
);
  import tsc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tok_pair_t         store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_pair = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_pair;
    end
  end

endmodule

[rtl/tsc_back.sv]
// Back end: splits queued token pairs into single requests on the output register.
`timescale 1ns / 1ps
module tsc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  tsc_pkg::tok_pair_t q_pair,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tsc_pkg::tok_t      out_tok
);
  import tsc_pkg::*;

  logic load;
  logic pend_valid;
  tok_t pend_tok;

  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !pend_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        // drain the held second token first
        out_tok    <= pend_tok;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_tok    <= q_pair.first;
        out_valid  <= 1'b1;
        pend_tok   <= q_pair.second;
        pend_valid <= q_pair.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/token_scanner_core.sv]
// Top level of the streaming token scanner.
//
// Input channel: one text byte on ch per request (in_valid / in_stall);
// byte 0 ends the text, closes any open token and adds an eof token.
// Output channel: one token per request (out_valid / out_stall) with kind,
// start_pos, length, line_no and last; last marks the final token caused
// by one input byte.
// A byte accepted at the input sends its tokens through the pair queue
// and then the output register. Bytes are taken one per cycle while the
// queue is not full; a byte that causes two tokens gives two requests,
// and the four-entry pair queue between scanner and output absorbs bursts.
// in_stall rises only when that queue is full, so a stall on the output
// side reaches the input after the queue fills; no token is dropped.
// Reset (rst, synchronous) empties the queue and output register, and sets
// offset 0 and line 1. After each end of text the scanner starts over at
// offset 0 and line 1.
`timescale 1ns / 1ps
module token_scanner_core (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [4:0]  kind,
  output logic [15:0] start_pos,
  output logic [15:0] length,
  output logic [15:0] line_no,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);
  import tsc_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  tok_pair_t push_pair, pop_pair;
  tok_t      out_tok;

  tsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_pair   (push_pair)
  );

  tsc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_pair (push_pair),
    .full      (q_full),
    .pop       (q_pop),
    .pop_pair  (pop_pair),
    .empty     (q_empty)
  );

  tsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pair    (pop_pair),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (out_tok)
  );

  assign kind      = out_tok.kind;
  assign start_pos = out_tok.start_pos;
  assign length    = out_tok.length;
  assign line_no   = out_tok.line_no;
  assign last      = out_tok.last;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for token_scanner_core: table, random texts and saturation run.
`timescale 1ns / 1ps
module testbench;
  import tsc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int LONG_LINES   = 66000;
  localparam int PRINT_LIMIT  = 100;
  localparam int MAX_GAP      = 20;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [1:0] NUM_LEAD   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_FRAC   = 2'd2;

  typedef enum logic [2:0] {
    SC_IDLE, SC_WORD, SC_NUMBER, SC_DQUOTE, SC_SQUOTE, SC_COMMENT
  } scan_mode_t;

  typedef struct {
    logic [7:0]  c;
    bit          known;
    kind_t       kind;
    logic [15:0] st;
    logic [15:0] len;
    logic [15:0] ln;
  } scan_row_t;

  typedef struct {
    bit   known;
    tok_t tok;
  } typed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  ch = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  kind;
  logic [15:0] start_pos;
  logic [15:0] length;
  logic [15:0] line_no;
  logic        last;
  logic        out_valid;
  logic        out_stall = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int bytes_taken = 0;
  int tokens_checked = 0;
  int texts_sent = 0;
  int phase_items = 0;

  // scanner shadow state
  scan_mode_t  sc_mode = SC_IDLE;
  logic [1:0]  num_phase = NUM_LEAD;
  logic [15:0] cur_pos = '0;
  logic [15:0] tok_begin = '0;
  logic [15:0] cur_line = 16'd1;
  logic [7:0]  word_chars [WORD_MAX];
  int          word_len = 0;
  bit          word_long = 1'b0;
  int          byte_tokens = 0;

  tok_t        tokens_due [$];
  typed_row_t  typed_rows [$];
  logic [7:0]  text_bytes [$];

  string kw_words [9] = '{"input", "output", "str", "num", "bool", "list",
                          "true", "false", "check"};
  string punct_chars = "(){}[]:";

  // Known tokens: the last token of each byte where the row is marked.
  scan_row_t dir_rows [27] = '{
    '{"(",    1'b1, K_LPAREN,   16'd0,  16'd1, 16'd1},
    '{")",    1'b1, K_RPAREN,   16'd1,  16'd1, 16'd1},
    '{"{",    1'b1, K_LBRACE,   16'd2,  16'd1, 16'd1},
    '{"}",    1'b1, K_RBRACE,   16'd3,  16'd1, 16'd1},
    '{"[",    1'b1, K_LBRACKET, 16'd4,  16'd1, 16'd1},
    '{"]",    1'b1, K_RBRACKET, 16'd5,  16'd1, 16'd1},
    '{":",    1'b1, K_COLON,    16'd6,  16'd1, 16'd1},
    '{8'hFF,  1'b1, K_ERR_CHAR, 16'd7,  16'd1, 16'd1},
    '{8'h80,  1'b1, K_ERR_CHAR, 16'd8,  16'd1, 16'd1},
    '{"#",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"\n",   1'b1, K_COMMENT,  16'd9,  16'd1, 16'd1},
    '{"-",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"-",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"7",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{".",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"5",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{":",    1'b1, K_COLON,    16'd16, 16'd1, 16'd2},
    '{"t",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"r",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"u",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"e",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{" ",    1'b1, K_BOOLEAN,  16'd17, 16'd4, 16'd2},
    '{"\"",   1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"\n",   1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{"\"",   1'b1, K_STRING,   16'd22, 16'd3, 16'd3},
    '{"'",    1'b0, K_EOF,      16'd0,  16'd0, 16'd0},
    '{8'h00,  1'b1, K_EOF,      16'd26, 16'd0, 16'd3}
  };

  token_scanner_core DUT (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .start_pos (start_pos),
    .length    (length),
    .line_no   (line_no),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit numeral_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void emit(input kind_t k, input logic [15:0] st, input logic [16:0] len);
    tok_t t;
    t.kind      = k;
    t.start_pos = st;
    t.length    = (len > 17'd65535) ? 16'hFFFF : len[15:0];
    t.line_no   = cur_line;
    t.last      = 1'b0;
    tokens_due.push_back(t);
    byte_tokens++;
  endfunction

  function void line_up();
    if (cur_line != LINE_MAX) cur_line++;
  endfunction

  // Advance the shadow scanner by one byte and queue the tokens it closes.
  function void lex_byte(input logic [7:0] c);
    logic [15:0] here;
    logic [15:0] span;
    logic [47:0] w;
    logic [7:0]  quote;
    kind_t       k;
    bit          rescan;
    bit          text_end;
    here = cur_pos;
    span = here - tok_begin;
    rescan = 1'b1;
    text_end = 1'b0;
    byte_tokens = 0;
    case (sc_mode)
      SC_WORD: begin
        if (letter_byte(c)) begin
          if (word_len < WORD_MAX) begin
            word_chars[word_len] = c;
            word_len++;
          end else begin
            word_long = 1'b1;
          end
          rescan = 1'b0;
        end else begin
          w = '0;
          for (int i = 0; i < word_len; i++) w = {w[39:0], word_chars[i]};
          case (w)
            {8'h00, "input"}:  k = K_INPUT;
            "output":          k = K_OUTPUT;
            {24'h0, "str"}:    k = K_STR;
            {24'h0, "num"}:    k = K_NUM;
            {16'h0, "bool"}:   k = K_BOOL;
            {16'h0, "list"}:   k = K_LIST;
            {16'h0, "true"}:   k = K_BOOLEAN;
            {8'h00, "false"}:  k = K_BOOLEAN;
            {8'h00, "check"}:  k = K_CHECK;
            default:           k = K_ERR_CHAR;
          endcase
          if (word_long) k = K_ERR_CHAR;
          emit(k, tok_begin, {1'b0, span});
          sc_mode = SC_IDLE;
        end
      end
      SC_NUMBER: begin
        if (num_phase == NUM_LEAD && c == CH_MINUS) begin
          num_phase = NUM_DIGITS;
          rescan = 1'b0;
        end else if (numeral_byte(c)) begin
          if (num_phase == NUM_LEAD) num_phase = NUM_DIGITS;
          rescan = 1'b0;
        end else if (c == CH_DOT && num_phase != NUM_FRAC) begin
          num_phase = NUM_FRAC;
          rescan = 1'b0;
        end else begin
          emit(K_NUMBER, tok_begin, {1'b0, span});
          sc_mode = SC_IDLE;
        end
      end
      SC_DQUOTE, SC_SQUOTE: begin
        quote = (sc_mode == SC_DQUOTE) ? CH_DQ : CH_SQ;
        if (c == CH_END) begin
          emit(K_ERR_STR, tok_begin, {1'b0, span});
          sc_mode = SC_IDLE;
        end else begin
          rescan = 1'b0;
          if (c == quote) begin
            emit(K_STRING, tok_begin, {1'b0, span} + 17'd1);
            sc_mode = SC_IDLE;
          end else if (c == CH_NL) begin
            line_up();
          end
        end
      end
      SC_COMMENT: begin
        if (c == CH_NL || c == CH_END) begin
          emit(K_COMMENT, tok_begin, {1'b0, span});
          sc_mode = SC_IDLE;
        end else begin
          rescan = 1'b0;
        end
      end
      default: ;
    endcase

    if (rescan) begin
      if (c == CH_END) begin
        emit(K_EOF, here, 17'd0);
        cur_pos = '0;
        cur_line = 16'd1;
        sc_mode = SC_IDLE;
        num_phase = NUM_LEAD;
        text_end = 1'b1;
      end else if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
      end else if (c == CH_NL) begin
        line_up();
      end else if (letter_byte(c)) begin
        sc_mode = SC_WORD;
        tok_begin = here;
        word_chars[0] = c;
        word_len = 1;
        word_long = 1'b0;
      end else if (numeral_byte(c) || c == CH_MINUS) begin
        sc_mode = SC_NUMBER;
        num_phase = NUM_LEAD;
        tok_begin = here;
      end else if (c == CH_DQ || c == CH_SQ) begin
        sc_mode = (c == CH_DQ) ? SC_DQUOTE : SC_SQUOTE;
        tok_begin = here;
      end else if (c == CH_HASH) begin
        sc_mode = SC_COMMENT;
        tok_begin = here;
      end else begin
        case (c)
          "(":     k = K_LPAREN;
          ")":     k = K_RPAREN;
          "{":     k = K_LBRACE;
          "}":     k = K_RBRACE;
          "[":     k = K_LBRACKET;
          "]":     k = K_RBRACKET;
          ":":     k = K_COLON;
          default: k = K_ERR_CHAR;
        endcase
        emit(k, here, 17'd1);
      end
    end

    if (!text_end && cur_pos != POS_MAX) cur_pos++;
    if (byte_tokens > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endfunction

  function void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    typed_row_t row;
    tok_t       want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        lex_byte(ch);
        row = typed_rows.pop_front();
        if (row.known) tokens_due[tokens_due.size() - 1] = row.tok;
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT)
            $display("%0t: token with no expectation, expected none, actual kind %0d start %0d",
                     $time, kind, start_pos);
        end else begin
          want = tokens_due.pop_front();
          tokens_checked++;
          check_field("kind", int'(want.kind), int'(kind));
          check_field("start_pos", int'(want.start_pos), int'(start_pos));
          check_field("length", int'(want.length), int'(length));
          check_field("line_no", int'(want.line_no), int'(line_no));
          check_field("last", int'(want.last), int'(last));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit known, input tok_t t);
    int         gap;
    typed_row_t row;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row.known = known;
    row.tok = t;
    typed_rows.push_back(row);
    ch <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every queued token has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_NL;
    endcase
  endfunction

  function void add_piece();
    int         n;
    logic [7:0] c;
    logic [7:0] q;
    string      w;
    case ($urandom_range(9))
      0: text_bytes.push_back(punct_chars[$urandom_range(6)]);
      1, 2: begin
        w = kw_words[$urandom_range(8)];
        for (int i = 0; i < w.len(); i++) begin
          c = w[i];
          // an upper-case first letter must not match
          if (i == 0 && $urandom_range(9) == 0) c = c - 8'd32;
          text_bytes.push_back(c);
        end
      end
      3: begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          c = 8'("a" + $urandom_range(25));
          if ($urandom_range(1)) c = c - 8'd32;
          text_bytes.push_back(c);
        end
      end
      4: begin
        text_bytes.push_back(($urandom_range(2) == 0) ? CH_MINUS :
                             8'("0" + $urandom_range(9)));
        if ($urandom_range(3) == 0) text_bytes.push_back(CH_MINUS);
        n = $urandom_range(4);
        repeat (n) text_bytes.push_back(8'("0" + $urandom_range(9)));
        if ($urandom_range(1)) begin
          text_bytes.push_back(CH_DOT);
          n = $urandom_range(3);
          repeat (n) text_bytes.push_back(8'("0" + $urandom_range(9)));
        end
      end
      5: begin
        q = $urandom_range(1) ? CH_DQ : CH_SQ;
        text_bytes.push_back(q);
        n = $urandom_range(6);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == q);
          text_bytes.push_back(c);
        end
        if ($urandom_range(11) != 0) text_bytes.push_back(q);
      end
      6: begin
        text_bytes.push_back(CH_HASH);
        n = $urandom_range(6);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
          text_bytes.push_back(c);
        end
        if ($urandom_range(9) != 0) text_bytes.push_back(CH_NL);
      end
      7: begin
        do c = 8'($urandom_range(1, 255));
        while (c inside {["0":"9"], ["A":"Z"], ["a":"z"], "(", ")", "{", "}", "[", "]",
                         ":", CH_MINUS, CH_DQ, CH_SQ, CH_HASH, CH_SP, CH_TAB, CH_CR, CH_NL});
        text_bytes.push_back(c);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) text_bytes.push_back(pick_blank());
      end
      default: text_bytes.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  task automatic send_text();
    int n;
    text_bytes.delete();
    n = $urandom_range(1, 10);
    repeat (n) begin
      add_piece();
      if ($urandom_range(9) < 6) text_bytes.push_back(pick_blank());
    end
    text_bytes.push_back(CH_END);
    foreach (text_bytes[i]) begin
      send_byte(text_bytes[i], 1'b0, '0);
      if (!(text_bytes[i] inside {CH_SP, CH_TAB, CH_CR})) phase_items++;
    end
    texts_sent++;
  endtask

  initial begin
    tok_t t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      t.kind = dir_rows[i].kind;
      t.start_pos = dir_rows[i].st;
      t.length = dir_rows[i].len;
      t.line_no = dir_rows[i].ln;
      t.last = 1'b1;
      send_byte(dir_rows[i].c, dir_rows[i].known, t);
    end
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_text();
      settle();
    end

    // one string spanning enough lines to saturate both offset and line count
    idle_pct = 0;
    stall_pct = 0;
    send_byte(CH_DQ, 1'b0, '0);
    repeat (LONG_LINES) send_byte(CH_NL, 1'b0, '0);
    send_byte(CH_DQ, 1'b0, '0);
    send_byte("x", 1'b0, '0);
    send_byte(CH_END, 1'b0, '0);
    settle();

    $display("Scanned %0d bytes: a directed table, %0d random texts under four idle/stall mixes,",
             bytes_taken, texts_sent);
    $display("and one text past the offset and line limits; %0d tokens compared.", tokens_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tsc_pkg.sv
rtl/tsc_front.sv
rtl/tsc_fifo.sv
rtl/tsc_back.sv
rtl/token_scanner_core.sv
tb/sv/testbench.sv
